### sv/per_track_scalar_kalman_defines.svh
// Assertion macros for the scalar Kalman range tracker.
`ifndef PER_TRACK_SCALAR_KALMAN_DEFINES_SVH
`define PER_TRACK_SCALAR_KALMAN_DEFINES_SVH
`ifndef SYNTHESIS
`define PTK_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTK_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTK_ASSERT(label, clk, rst_n, prop, msg)
`define PTK_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### sv/ptk_pkg.sv
// Package: types, constants and register codes of the scalar Kalman tracker.
`default_nettype none
package ptk_pkg;
	localparam int TRACK_COUNT_DEF = 64;
	localparam int GAIN_FRAC_DEF   = 16;

	localparam logic [2:0] REG_TIME_STEP = 3'd0;
	localparam logic [2:0] REG_INIT_PV   = 3'd1;
	localparam logic [2:0] REG_INIT_VV   = 3'd2;
	localparam logic [2:0] REG_QP        = 3'd3;
	localparam logic [2:0] REG_QV        = 3'd4;
	localparam logic [2:0] REG_R         = 3'd5;

	localparam logic [15:0] DT_RST = 16'd6554;
	localparam logic [31:0] IPV_RST = 32'd6553600;
	localparam logic [31:0] IVV_RST = 32'd1638400;
	localparam logic [31:0] QP_RST = 32'd65536;
	localparam logic [31:0] QV_RST = 32'd32768;
	localparam logic [31:0] R_RST = 32'd14745600;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_STEP,
		ST_PRED,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_CORR,
		ST_VAR,
		ST_NEXT,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (x > hi) sat32 = 32'sh7fffffff;
		else if (x < lo) sat32 = 32'sh80000000;
		else sat32 = x[31:0];
	endfunction
endpackage
`default_nettype wire

### sv/ptk_div.sv
// Restoring divider: one quotient bit per cycle.
`default_nettype none
module ptk_div import ptk_pkg::*; #(
	parameter int NUM_W = 50,
	parameter int DEN_W = 33
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output div_ctl_t              ctl,
	output logic [NUM_W-1:0]      quot
);
	localparam int CW = $clog2(NUM_W + 1);
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [NUM_W-1:0] q_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0] trial;

	assign trial = {rem_q, q_q[NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DEN_W'(trial - {1'b0, den_q});
				q_q <= {q_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				q_q <= {q_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy = busy_q;
	assign ctl.done = done_q;
	assign quot = q_q;
endmodule
`default_nettype wire

### sv/per_track_scalar_kalman.sv
// Top level: per-track scalar Kalman range tracker with shared divider.
//
// Channel  | Signals                                      | Handshake
// ---------+----------------------------------------------+----------------------
// input    | track_number, measured_distance/velocity     | start & !busy
// result   | result_track, filtered_*, new_track          | done strobe, 1 cycle
// config   | cfg_index, cfg_data                          | cfg_valid & cfg_ready
//
// After an input transfer busy stays high through READ, LOAD and WRITE on a new track;
// an update runs READ, STEP, PRED, then per filter DIV_START, DIV_WAIT, CORR, VAR, NEXT,
// then WRITE; each filter waits on the bit-serial divider, run once per filter.
// A zero gain denominator skips the divider for that filter. Reset clears the valid
// bits, state and done and presets config registers; the store needs no clearing pass.
// Results cannot be stalled; done rises as busy falls, and the next transfer may be
// taken in the done cycle.
`default_nettype none
`include "per_track_scalar_kalman_defines.svh"
module per_track_scalar_kalman import ptk_pkg::*; #(
	parameter int TRACK_COUNT = TRACK_COUNT_DEF,
	parameter int GAIN_FRACTION_BITS = GAIN_FRAC_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [5:0]         track_number,
	input  wire logic signed [31:0] measured_distance,
	input  wire logic signed [31:0] measured_velocity,
	output logic                    done,
	output logic [5:0]              result_track,
	output logic signed [31:0]      filtered_distance,
	output logic signed [31:0]      filtered_velocity,
	output logic                    new_track,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	localparam int IW = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
	localparam int G = GAIN_FRACTION_BITS;
	localparam int NUM_W = 32 + G;
	localparam int DEN_W = 33;

	// configuration registers
	logic [15:0] dt_q;
	logic [31:0] ipv_q, ivv_q, qp_q, qv_q, r_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= DT_RST;
			ipv_q <= IPV_RST;
			ivv_q <= IVV_RST;
			qp_q <= QP_RST;
			qv_q <= QV_RST;
			r_q <= R_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TIME_STEP: dt_q <= cfg_data[15:0];
				REG_INIT_PV:   ipv_q <= cfg_data;
				REG_INIT_VV:   ivv_q <= cfg_data;
				REG_QP:        qp_q <= cfg_data;
				REG_QV:        qv_q <= cfg_data;
				REG_R:         r_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// track store: valid bits in flops, payload in a memory with registered read
	logic [TRACK_COUNT-1:0] valid_q;
	logic [127:0] mem [TRACK_COUNT];
	logic [127:0] rd_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] idx_in;
	logic [5:0] tn_q;
	logic signed [31:0] md_q, mv_q;
	logic mem_we;
	logic [127:0] wr_data;

	// fold the track number into the table with a constant lookup
	always_comb begin
		idx_in = '0;
		for (int i = 0; i < 64; i++)
			if (track_number == 6'(i)) idx_in = IW'(i % TRACK_COUNT);
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[idx_q] <= wr_data;
		rd_q <= mem[idx_q];
	end

	// sequencer
	state_t state_q, state_d;
	logic phase_q;           // 0: distance filter, 1: velocity filter
	logic signed [33:0] pred_q;  // predicted estimate
	logic [31:0] p_q;            // predicted variance
	logic signed [65:0] acc_q;   // shared product register
	logic [G:0] gain_q;
	logic [G:0] gain_d;
	logic [G:0] gain_rem;
	logic signed [31:0] ed_q, ev_q;
	logic [31:0] vd_q, vv_q;
	logic newt_q, done_q;
	div_ctl_t dctl;
	logic [NUM_W-1:0] quot;
	logic div_start;
	logic [32:0] den;
	logic [32:0] psum_d, psum_v;
	logic signed [31:0] meas;

	assign den = {1'b0, p_q} + {1'b0, r_q};
	assign meas = phase_q ? mv_q : md_q;
	assign psum_d = {1'b0, rd_q[95:64]} + {1'b0, qp_q};
	assign psum_v = {1'b0, rd_q[127:96]} + {1'b0, qv_q};
	// zero gain when both variances vanish, else the quotient
	assign gain_d = (den == '0) ? '0 : quot[G:0];
	assign gain_rem = {1'b1, {G{1'b0}}} - gain_q;

	ptk_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({p_q, G'(0)}), .den(den), .ctl(dctl), .quot(quot)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (start) state_d = ST_READ;
			ST_READ:      state_d = valid_q[idx_q] ? ST_STEP : ST_LOAD;
			ST_LOAD:      state_d = ST_WRITE;
			ST_STEP:      state_d = ST_PRED;
			ST_PRED:      state_d = ST_DIV_START;
			ST_DIV_START: state_d = (den == '0) ? ST_CORR : ST_DIV_WAIT;
			ST_DIV_WAIT:  if (dctl.done) state_d = ST_CORR;
			ST_CORR:      state_d = ST_VAR;
			ST_VAR:       state_d = ST_NEXT;
			ST_NEXT:      state_d = phase_q ? ST_WRITE : ST_DIV_START;
			ST_WRITE:     state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		div_start = (state_q == ST_DIV_START) && (den != '0);
		mem_we = (state_q == ST_WRITE);
		busy = (state_q != ST_IDLE);
	end
	assign wr_data = {vv_q, vd_q, ev_q, ed_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == ST_WRITE);
			if (state_q == ST_WRITE) valid_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (start) begin
				tn_q <= track_number;
				idx_q <= idx_in;
				md_q <= measured_distance;
				mv_q <= measured_velocity;
				phase_q <= 1'b0;
			end
			ST_READ: newt_q <= !valid_q[idx_q];
			ST_LOAD: begin
				ed_q <= md_q;
				ev_q <= mv_q;
				vd_q <= ipv_q;
				vv_q <= ivv_q;
			end
			ST_STEP: begin
				// v * dt, rounded, and predicted variances
				acc_q <= 66'($signed(rd_q[63:32])) * 66'($signed({1'b0, dt_q})) +
					66'sd32768;
				ev_q <= rd_q[63:32];
				vd_q <= psum_d[32] ? 32'hffffffff : psum_d[31:0];
				vv_q <= psum_v[32] ? 32'hffffffff : psum_v[31:0];
			end
			ST_PRED: begin
				pred_q <= 34'(sat32(66'($signed(rd_q[31:0])) - (acc_q >>> 16)));
				p_q <= vd_q;
			end
			ST_DIV_WAIT: ;
			ST_CORR: begin
				gain_q <= gain_d;
				acc_q <= 66'($signed({1'b0, gain_d})) * 66'(34'(meas) - pred_q) +
					66'(66'sd1 <<< (G - 1));
			end
			ST_VAR: begin
				if (phase_q) ev_q <= sat32(66'(pred_q) + (acc_q >>> G));
				else ed_q <= sat32(66'(pred_q) + (acc_q >>> G));
				acc_q <= 66'(gain_rem) * 66'(p_q) + 66'(66'sd1 <<< (G - 1));
			end
			ST_NEXT: begin
				if (phase_q) vv_q <= 32'(acc_q >> G);
				else begin
					vd_q <= 32'(acc_q >> G);
					pred_q <= 34'(ev_q);
					p_q <= vv_q;
				end
				phase_q <= 1'b1;
			end
			ST_WRITE: begin
				result_track <= tn_q;
				filtered_distance <= ed_q;
				filtered_velocity <= ev_q;
				new_track <= newt_q;
			end
			default: ;
		endcase
	end

	assign done = done_q;

	`PTK_ASSERT(a_done_idle, clk, arst_n, done |-> (state_q == ST_IDLE), "done outside idle")
	`PTK_ASSERT(a_write_done, clk, arst_n, mem_we |=> done, "write without strobe")
	`PTK_ASSERT(a_div_busy, clk, arst_n, dctl.busy |-> (state_q == ST_DIV_WAIT), "divider stray")
endmodule
`default_nettype wire
